FILE: design/dea_pkg.sv
// Shared constants for the discrete entropy accumulator.
// No dependencies; the top level, fill, front and back files refer to it by scoped names.
`default_nettype none
package dea_pkg;

	localparam int LOG_W  = 24;   // log2 table entry, Q0.24
	localparam int FRAC_W = 32;   // normalized fraction of a mass
	localparam int WGT_W  = 16;   // interpolation weight
	localparam int SUM_W  = 40;   // running sum, Q16.24
	localparam int OUT_W  = 32;   // emitted entropy, Q8.24

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
	localparam logic [LOG_W:0]   ONE_Q24 = {1'b1, {LOG_W{1'b0}}};

endpackage
`default_nettype wire

FILE: design/discrete_entropy_accumulator.sv
// Top level of the discrete entropy accumulator: front, item queue, back, table.
// Depends on dea_pkg, dea_ram, dea_fifo, dea_fill, dea_front, dea_back.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------
//  input   | push / full        | mass, last_point
//  result  | empty / pop        | entropy_bits, saturated (on last item)
//
// One item per cycle sustained while no result is blocked; with no stall a result enters
// the result queue once its last item has passed the item queue, the table read, the
// interpolation multiply, the log subtraction and the p*log multiply, then the sum.
// After reset the table is built one bit a cycle, with full held high until it ends.
// A result blocked by a full result queue stalls the back end; the front
// keeps taking items until the item queue fills.
`default_nettype none
module discrete_entropy_accumulator #(
	parameter int LOG_TABLE_DEPTH = 1024,
	parameter int MASS_FRAC_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [MASS_FRAC_BITS:0]       mass,
	input  wire logic                          last_point,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [dea_pkg::OUT_W-1:0]          entropy_bits,
	output logic                               saturated
);

	localparam int EW  = $clog2(MASS_FRAC_BITS);
	localparam int AW  = $clog2(LOG_TABLE_DEPTH);
	localparam int MQW = dea_pkg::FRAC_W + MASS_FRAC_BITS + EW + 2;
	localparam int OQW = dea_pkg::OUT_W + 1;

	logic                         fill_done;
	logic                         fill_we;
	logic [AW-1:0]                fill_waddr;
	logic [dea_pkg::LOG_W-1:0]    fill_wdata;

	logic                         f_no_term;
	logic [EW-1:0]                f_expo;
	logic [MASS_FRAC_BITS-1:0]    f_frac_mass;
	logic [dea_pkg::FRAC_W-1:0]   f_frac;

	logic                         mid_full;
	logic                         mid_empty;
	logic                         mid_pop;
	logic [MQW-1:0]               mid_wdata;
	logic [MQW-1:0]               mid_rdata;

	logic                         ram_re;
	logic [AW-1:0]                ram_raddr0;
	logic [AW-1:0]                ram_raddr1;
	logic [dea_pkg::LOG_W-1:0]    ram_rdata0;
	logic [dea_pkg::LOG_W-1:0]    ram_rdata1;

	logic                         out_full;
	logic                         out_push;
	logic [dea_pkg::OUT_W-1:0]    out_entropy;
	logic                         out_sat;
	logic [OQW-1:0]               out_rdata;

	assign full = !fill_done || mid_full;

	dea_fill #(
		.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
	) u_fill (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.done  (fill_done)
	);

	dea_ram #(
		.WIDTH(dea_pkg::LOG_W),
		.DEPTH(LOG_TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (ram_re),
		.raddr0(ram_raddr0),
		.raddr1(ram_raddr1),
		.rdata0(ram_rdata0),
		.rdata1(ram_rdata1)
	);

	dea_front #(
		.MASS_FRAC_BITS(MASS_FRAC_BITS)
	) u_front (
		.mass     (mass),
		.no_term  (f_no_term),
		.expo     (f_expo),
		.frac_mass(f_frac_mass),
		.frac     (f_frac)
	);

	assign mid_wdata = {last_point, f_no_term, f_expo, f_frac_mass, f_frac};

	dea_fifo #(
		.WIDTH(MQW),
		.DEPTH(2)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	dea_back #(
		.MASS_FRAC_BITS (MASS_FRAC_BITS),
		.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mid_empty   (mid_empty),
		.mid_pop     (mid_pop),
		.in_no_term  (mid_rdata[MQW-2]),
		.in_expo     (mid_rdata[MQW-3 -: EW]),
		.in_frac_mass(mid_rdata[dea_pkg::FRAC_W +: MASS_FRAC_BITS]),
		.in_frac     (mid_rdata[dea_pkg::FRAC_W-1:0]),
		.in_last     (mid_rdata[MQW-1]),
		.ram_re      (ram_re),
		.ram_raddr0  (ram_raddr0),
		.ram_raddr1  (ram_raddr1),
		.ram_rdata0  (ram_rdata0),
		.ram_rdata1  (ram_rdata1),
		.out_full    (out_full),
		.out_push    (out_push),
		.out_entropy (out_entropy),
		.out_sat     (out_sat)
	);

	dea_fifo #(
		.WIDTH(OQW),
		.DEPTH(2)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata ({out_sat, out_entropy}),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign entropy_bits = out_rdata[dea_pkg::OUT_W-1:0];
	assign saturated    = out_rdata[dea_pkg::OUT_W];

	// no item may enter while the table is still being built
	a_no_push_during_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_done |-> full)
		else $error("item accepted before table fill completed");

	a_fill_stays_done: assert property (@(posedge clk) disable iff (!arst_n)
		fill_done |=> fill_done)
		else $error("table fill restarted");

	// the back end must hold a result rather than drop it
	a_no_result_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into full result queue");

	a_no_pop_from_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("back end took from empty item queue");

endmodule
`default_nettype wire

FILE: design/dea_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none
module dea_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule
`default_nettype wire

FILE: design/dea_fifo.sv
// Small register queue with combinational head read.
// No dependencies.
`default_nettype none
module dea_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/dea_fill.sv
// Builds the log2(1+f) table after reset by repeated squaring, one bit a cycle.
// Depends on dea_pkg.
`default_nettype none
module dea_fill #(
	parameter int LOG_TABLE_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	output logic                                    we,
	output logic [$clog2(LOG_TABLE_DEPTH)-1:0]      waddr,
	output logic [dea_pkg::LOG_W-1:0]               wdata,
	output logic                                    done
);

	localparam int AW    = $clog2(LOG_TABLE_DEPTH);
	localparam int RMW   = $clog2(LOG_TABLE_DEPTH) + 1;
	localparam int QSTEP = (1 << 30) / LOG_TABLE_DEPTH;
	localparam int RSTEP = (1 << 30) % LOG_TABLE_DEPTH;
	localparam int CNW   = $clog2(dea_pkg::LOG_W);

	logic                      done_q;
	logic [AW-1:0]             i_q;
	logic [29:0]               q_q;
	logic [RMW-1:0]            rem_q;
	logic [30:0]               x_q;
	logic [dea_pkg::LOG_W-1:0] acc_q;
	logic [CNW-1:0]            cnt_q;

	logic [61:0]               sq;
	logic [31:0]               sq_hi;
	logic                      bit_n;
	logic [30:0]               x_n;
	logic [dea_pkg::LOG_W-1:0] acc_n;
	logic                      entry_end;
	logic [RMW-1:0]            rsum;
	logic                      wrap;
	logic [RMW-1:0]            rem_n;
	logic [29:0]               q_n;

	// x is Q1.30 and stays below 2.0 between steps
	assign sq        = 62'(x_q) * 62'(x_q);
	assign sq_hi     = sq[61:30];
	assign bit_n     = sq_hi[31];
	assign x_n       = bit_n ? sq_hi[31:1] : sq_hi[30:0];
	assign acc_n     = {acc_q[dea_pkg::LOG_W-2:0], bit_n};
	assign entry_end = (cnt_q == CNW'(dea_pkg::LOG_W - 1));

	// floor(i * 2^30 / depth) kept as quotient plus remainder
	assign rsum  = rem_q + RMW'(RSTEP);
	assign wrap  = (rsum >= RMW'(LOG_TABLE_DEPTH));
	assign rem_n = wrap ? rsum - RMW'(LOG_TABLE_DEPTH) : rsum;
	assign q_n   = q_q + 30'(QSTEP) + {29'd0, wrap};

	assign we    = !done_q && entry_end;
	assign waddr = i_q;
	assign wdata = acc_n;
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			i_q    <= '0;
			q_q    <= '0;
			rem_q  <= '0;
			x_q    <= 31'h4000_0000;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (!done_q) begin
			if (entry_end) begin
				cnt_q <= '0;
				if (i_q == AW'(LOG_TABLE_DEPTH - 1)) begin
					done_q <= 1'b1;
				end else begin
					i_q   <= i_q + AW'(1);
					q_q   <= q_n;
					rem_q <= rem_n;
					x_q   <= 31'h4000_0000 + 31'(q_n);
				end
			end else begin
				cnt_q <= cnt_q + CNW'(1);
				x_q   <= x_n;
				acc_q <= acc_n;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/dea_front.sv
// Front end: classifies a mass and normalizes it to 2^e * (1 + f).
// Depends on dea_pkg.
`default_nettype none
module dea_front #(
	parameter int MASS_FRAC_BITS = 16
) (
	input  wire logic [MASS_FRAC_BITS:0]           mass,
	output logic                                   no_term,
	output logic [$clog2(MASS_FRAC_BITS)-1:0]      expo,
	output logic [MASS_FRAC_BITS-1:0]              frac_mass,
	output logic [dea_pkg::FRAC_W-1:0]             frac
);

	localparam int EW = $clog2(MASS_FRAC_BITS);
	localparam int SW = MASS_FRAC_BITS + dea_pkg::FRAC_W;

	logic [5:0]    sh;
	logic [SW-1:0] shl;

	assign frac_mass = mass[MASS_FRAC_BITS-1:0];
	// zero, or one and above (top bit set): no contribution
	assign no_term   = (mass == '0) || mass[MASS_FRAC_BITS];

	always_comb begin
		expo = '0;
		for (int k = 0; k < MASS_FRAC_BITS; k++) begin
			if (frac_mass[k]) begin
				expo = EW'(k);
			end
		end
	end

	// shifting the leading one to bit 32 leaves the fraction below it
	assign sh   = 6'(dea_pkg::FRAC_W) - 6'(expo);
	assign shl  = SW'(frac_mass) << sh;
	assign frac = shl[dea_pkg::FRAC_W-1:0];

endmodule
`default_nettype wire

FILE: design/dea_back.sv
// Back end: table lookup, interpolation, -p*log2(p) and saturating accumulate.
// Depends on dea_pkg; reads the table RAM instanced at the top level.
`default_nettype none
module dea_back #(
	parameter int MASS_FRAC_BITS  = 16,
	parameter int LOG_TABLE_DEPTH = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 mid_empty,
	output logic                                      mid_pop,
	input  wire logic                                 in_no_term,
	input  wire logic [$clog2(MASS_FRAC_BITS)-1:0]    in_expo,
	input  wire logic [MASS_FRAC_BITS-1:0]            in_frac_mass,
	input  wire logic [dea_pkg::FRAC_W-1:0]           in_frac,
	input  wire logic                                 in_last,
	output logic                                      ram_re,
	output logic [$clog2(LOG_TABLE_DEPTH)-1:0]        ram_raddr0,
	output logic [$clog2(LOG_TABLE_DEPTH)-1:0]        ram_raddr1,
	input  wire logic [dea_pkg::LOG_W-1:0]            ram_rdata0,
	input  wire logic [dea_pkg::LOG_W-1:0]            ram_rdata1,
	input  wire logic                                 out_full,
	output logic                                      out_push,
	output logic [dea_pkg::OUT_W-1:0]                 out_entropy,
	output logic                                      out_sat
);

	localparam int MFB  = MASS_FRAC_BITS;
	localparam int EW   = $clog2(MFB);
	localparam int AW   = $clog2(LOG_TABLE_DEPTH);
	localparam int GW   = dea_pkg::FRAC_W + AW;
	localparam int NLW  = $clog2(MFB + 1) + dea_pkg::LOG_W;
	localparam int PW   = MFB + NLW;
	localparam int LW1  = dea_pkg::LOG_W + 1;
	localparam int DPW  = LW1 + dea_pkg::WGT_W;

	logic                        adv;
	logic [GW-1:0]               g;
	logic [AW-1:0]               idx;
	logic [AW:0]                 idx1;
	logic                        hi_end;

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic                        last_s1, last_s2, last_s3, last_s4;
	logic                        nt_s1, nt_s2, nt_s3;
	logic [EW-1:0]               e_s1, e_s2;
	logic [MFB-1:0]              p_s1, p_s2, p_s3;
	logic [dea_pkg::WGT_W-1:0]   w_s1;
	logic                        end_s1;
	logic [DPW-1:0]              prod_s2;
	logic [dea_pkg::LOG_W-1:0]   lo_s2;
	logic [NLW-1:0]              nl_s3;
	logic [NLW-1:0]              term_s4;

	logic [LW1-1:0]              hi_v;
	logic [LW1-1:0]              diff;
	logic [LW1-1:0]              lfrac;
	logic [PW-1:0]               pn;

	logic [dea_pkg::SUM_W-1:0]   sum_q;
	logic                        ovf_q;
	logic [dea_pkg::SUM_W:0]     sum_ext;
	logic [dea_pkg::SUM_W-1:0]   sum_n;
	logic                        ovf_n;

	// the accumulate stage is the only one that can block
	assign adv     = !(v_s4 && last_s4 && out_full);
	assign mid_pop = adv && !mid_empty;

	assign g      = GW'(in_frac) * GW'(LOG_TABLE_DEPTH);
	assign idx    = g[GW-1:dea_pkg::FRAC_W];
	assign idx1   = {1'b0, idx} + (AW+1)'(1);
	assign hi_end = (idx1 == (AW+1)'(LOG_TABLE_DEPTH));

	assign ram_re     = adv;
	assign ram_raddr0 = idx;
	assign ram_raddr1 = hi_end ? '0 : idx1[AW-1:0];

	// entry past the end of the table is log2(2) = 1.0
	assign hi_v  = end_s1 ? dea_pkg::ONE_Q24 : {1'b0, ram_rdata1};
	assign diff  = hi_v - {1'b0, ram_rdata0};
	assign lfrac = {1'b0, lo_s2} + prod_s2[DPW-1:dea_pkg::WGT_W];
	assign pn    = PW'(p_s3) * PW'(nl_s3);

	assign sum_ext = {1'b0, sum_q} + (dea_pkg::SUM_W+1)'(term_s4);
	assign sum_n   = sum_ext[dea_pkg::SUM_W] ? dea_pkg::SUM_MAX : sum_ext[dea_pkg::SUM_W-1:0];
	assign ovf_n   = ovf_q || sum_ext[dea_pkg::SUM_W];

	assign out_push    = adv && v_s4 && last_s4;
	assign out_entropy = (sum_n[dea_pkg::SUM_W-1:dea_pkg::OUT_W] != '0) ?
		dea_pkg::OUT_MAX : sum_n[dea_pkg::OUT_W-1:0];
	assign out_sat     = ovf_n || (sum_n[dea_pkg::SUM_W-1:dea_pkg::OUT_W] != '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= in_last;
			nt_s1   <= in_no_term;
			e_s1    <= in_expo;
			p_s1    <= in_frac_mass;
			w_s1    <= g[dea_pkg::FRAC_W-1:dea_pkg::WGT_W];
			end_s1  <= hi_end;

			last_s2 <= last_s1;
			nt_s2   <= nt_s1;
			e_s2    <= e_s1;
			p_s2    <= p_s1;
			lo_s2   <= ram_rdata0;
			prod_s2 <= DPW'(diff) * DPW'(w_s1);

			last_s3 <= last_s2;
			nt_s3   <= nt_s2;
			p_s3    <= p_s2;
			nl_s3   <= ((NLW'(MFB) - NLW'(e_s2)) << dea_pkg::LOG_W) - NLW'(lfrac);

			last_s4 <= last_s3;
			term_s4 <= nt_s3 ? '0 : pn[PW-1:MFB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= !mid_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				if (last_s4) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_n;
					ovf_q <= ovf_n;
				end
			end
		end
	end

endmodule
`default_nettype wire
